### rtl/c2rb_pkg.sv
// Shared constants, types and the arctangent table of the range and bearing converter.
// Used by every module of the block; depends on nothing else.
package c2rb_pkg;

  localparam int COORD_WIDTH  = 24;
  localparam int ANGLE_WIDTH  = 16;
  localparam int GUARD_BITS   = 30;
  localparam int CORDIC_STEPS = 28;
  localparam int SQRT_STEPS   = COORD_WIDTH;
  localparam int NUM_CELLS    = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
  localparam int CELL_IDX_W   = $clog2(NUM_CELLS);
  localparam int ATAN_IDX_W   = $clog2(CORDIC_STEPS);

  localparam int CX_W   = COORD_WIDTH + GUARD_BITS + 2;
  localparam int Z_W    = 34;
  localparam int SUM_W  = 2 * COORD_WIDTH;
  localparam int REM_W  = SUM_W + 1;
  localparam int ROOT_W = COORD_WIDTH;

  localparam logic [31:0] EIGHTH_TURN  = 32'h2000_0000;
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [31:0] HALF_STEP    = 32'(64'd1 << (31 - ANGLE_WIDTH));
  localparam logic [ANGLE_WIDTH-1:0] COMPASS_OFFSET = ANGLE_WIDTH'(1 << (ANGLE_WIDTH - 2));

  localparam logic [31:0] ATAN_TURNS [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005
  };

  typedef struct packed {
    logic x_neg;
    logic y_neg;
    logic steep;
    logic origin;
  } quad_flags_t;

  typedef struct packed {
    logic signed [CX_W-1:0] cx;
    logic signed [CX_W-1:0] cy;
    logic signed [Z_W-1:0]  z;
    logic [SUM_W-1:0]       rem;
    logic [ROOT_W-1:0]      root;
    quad_flags_t            flags;
  } cell_data_t;

  function automatic logic [31:0] atan_turn(input logic [CELL_IDX_W-1:0] i);
    logic [31:0] val;
    val = '0;
    if (32'(i) < CORDIC_STEPS) begin
      val = ATAN_TURNS[i[ATAN_IDX_W-1:0]];
    end
    return val;
  endfunction

endpackage

### rtl/c2rb_front.sv
// Front end: magnitudes, octant folding, squares and their sum, in three stages.
// Depends on c2rb_pkg.
module c2rb_front import c2rb_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          up_valid,
  output logic                          ready,
  input  logic signed [COORD_WIDTH-1:0] x_coord,
  input  logic signed [COORD_WIDTH-1:0] y_coord,
  input  logic signed [COORD_WIDTH-1:0] z_coord,
  output logic                          valid,
  output cell_data_t                    data,
  input  logic                          dn_ready
);

  logic                   s1_valid, s2_valid;
  logic                   r1, r2, r3;
  logic [COORD_WIDTH-1:0] ax, ay, az;
  logic [COORD_WIDTH-1:0] big1, small1, z1;
  quad_flags_t            flags1;
  logic [COORD_WIDTH-1:0] big2, small2;
  logic [SUM_W-1:0]       sq_big, sq_small, sq_z;
  logic [SUM_W-1:0]       sq_big2, sq_small2, sq_z2;
  quad_flags_t            flags2;
  logic [SUM_W-1:0]       sum_next;

  assign r3    = !valid || dn_ready;
  assign r2    = !s2_valid || r3;
  assign r1    = !s1_valid || r2;
  assign ready = r1;

  assign ax = x_coord[COORD_WIDTH-1] ? COORD_WIDTH'(-x_coord) : COORD_WIDTH'(x_coord);
  assign ay = y_coord[COORD_WIDTH-1] ? COORD_WIDTH'(-y_coord) : COORD_WIDTH'(y_coord);
  assign az = z_coord[COORD_WIDTH-1] ? COORD_WIDTH'(-z_coord) : COORD_WIDTH'(z_coord);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      valid    <= 1'b0;
    end else begin
      if (r1) s1_valid <= up_valid;
      if (r2) s2_valid <= s1_valid;
      if (r3) valid    <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (r1) begin
      big1          <= (ay > ax) ? ay : ax;
      small1        <= (ay > ax) ? ax : ay;
      z1            <= az;
      flags1.x_neg  <= x_coord[COORD_WIDTH-1];
      flags1.y_neg  <= y_coord[COORD_WIDTH-1];
      flags1.steep  <= ay > ax;
      flags1.origin <= (ax == '0) && (ay == '0);
    end
  end

  assign sq_big   = SUM_W'(big1) * SUM_W'(big1);
  assign sq_small = SUM_W'(small1) * SUM_W'(small1);
  assign sq_z     = SUM_W'(z1) * SUM_W'(z1);

  always_ff @(posedge clk) begin
    if (r2) begin
      big2      <= big1;
      small2    <= small1;
      sq_big2   <= sq_big;
      sq_small2 <= sq_small;
      sq_z2     <= sq_z;
      flags2    <= flags1;
    end
  end

  assign sum_next = sq_big2 + sq_small2 + sq_z2;

  always_ff @(posedge clk) begin
    if (r3) begin
      data.cx    <= $signed({{(CX_W-COORD_WIDTH-GUARD_BITS){1'b0}}, big2, {GUARD_BITS{1'b0}}});
      data.cy    <= $signed({{(CX_W-COORD_WIDTH-GUARD_BITS){1'b0}}, small2,
                             {GUARD_BITS{1'b0}}});
      data.z     <= '0;
      data.rem   <= sum_next;
      data.root  <= '0;
      data.flags <= flags2;
    end
  end

endmodule

### rtl/c2rb_cell.sv
// One cell of the chain: a vectoring rotation step and, below SQRT_STEPS, one square root digit.
// Depends on c2rb_pkg.
module c2rb_cell import c2rb_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [CELL_IDX_W-1:0] idx,
  input  logic                  up_valid,
  output logic                  ready,
  input  cell_data_t            up_data,
  output logic                  valid,
  output cell_data_t            data,
  input  logic                  dn_ready
);

  logic                   cordic_on, sqrt_on;
  logic [CELL_IDX_W-1:0]  k;
  logic signed [CX_W-1:0] dx, dy;
  logic signed [Z_W-1:0]  z_step;
  logic [REM_W-1:0]       trial;
  cell_data_t             data_next;

  assign ready     = !valid || dn_ready;
  assign cordic_on = 32'(idx) < CORDIC_STEPS;
  assign sqrt_on   = 32'(idx) < SQRT_STEPS;
  assign k         = CELL_IDX_W'(SQRT_STEPS - 1) - idx;
  assign dx        = up_data.cy >>> idx;
  assign dy        = up_data.cx >>> idx;
  assign z_step    = $signed({{(Z_W-32){1'b0}}, atan_turn(idx)});
  assign trial     = ((REM_W'(up_data.root) << 1) + (REM_W'(1) << k)) << k;

  always_comb begin
    data_next = up_data;
    if (cordic_on) begin
      if (!up_data.cy[CX_W-1]) begin
        data_next.cx = up_data.cx + dx;
        data_next.cy = up_data.cy - dy;
        data_next.z  = up_data.z + z_step;
      end else begin
        data_next.cx = up_data.cx - dx;
        data_next.cy = up_data.cy + dy;
        data_next.z  = up_data.z - z_step;
      end
    end
    if (sqrt_on && ({1'b0, up_data.rem} >= trial)) begin
      data_next.rem  = up_data.rem - trial[SUM_W-1:0];
      data_next.root = up_data.root | (ROOT_W'(1) << k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      data <= data_next;
    end
  end

endmodule

### rtl/c2rb_unfold.sv
// Output stage: octant and quadrant unfold, bearing rounding, compass option, range rounding.
// Depends on c2rb_pkg.
module c2rb_unfold import c2rb_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   compass_mode,
  input  logic                   up_valid,
  output logic                   ready,
  input  cell_data_t             up_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [COORD_WIDTH-1:0] range_out,
  output logic [ANGLE_WIDTH-1:0] bearing_out
);

  logic [31:0]            oct, folded, turn, rounded;
  logic [ANGLE_WIDTH-1:0] bearing_math, bearing_next;
  logic [COORD_WIDTH-1:0] range_next;

  assign ready = !out_valid || !out_stall;

  always_comb begin
    if (up_data.z[Z_W-1]) begin
      oct = '0;
    end else if (up_data.z > $signed({{(Z_W-32){1'b0}}, EIGHTH_TURN})) begin
      oct = EIGHTH_TURN;
    end else begin
      oct = up_data.z[31:0];
    end
  end

  assign folded = up_data.flags.steep ? (QUARTER_TURN - oct) : oct;

  always_comb begin
    priority if (up_data.flags.origin) begin
      turn = '0;
    end else if (up_data.flags.x_neg && !up_data.flags.y_neg) begin
      turn = HALF_TURN - folded;
    end else if (up_data.flags.x_neg && up_data.flags.y_neg) begin
      turn = HALF_TURN + folded;
    end else if (up_data.flags.y_neg) begin
      turn = '0 - folded;
    end else begin
      turn = folded;
    end
  end

  assign rounded      = turn + HALF_STEP;
  assign bearing_math = rounded[31 -: ANGLE_WIDTH];
  assign bearing_next = compass_mode ? (COMPASS_OFFSET - bearing_math) : bearing_math;
  assign range_next   = (up_data.rem > SUM_W'(up_data.root)) ? (up_data.root + ROOT_W'(1))
                                                             : up_data.root;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ready) begin
      range_out   <= range_next;
      bearing_out <= bearing_next;
    end
  end

endmodule

### rtl/cartesian_to_range_bearing.sv
// Rectangular to polar converter: range and bearing of a radar point, fully pipelined.
// From an accepted input word to its output word, data pass through three front
// stages, a chain of 28 cells set by the rotation steps, and one output register.
// Throughput is one word per clock while out_stall is low; a stalled output holds only as many words as stages.
// Synchronous reset empties the pipeline and clears compass_mode to mathematical angles.
// Depends on c2rb_pkg, c2rb_front, c2rb_cell and c2rb_unfold.
module cartesian_to_range_bearing import c2rb_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] x_coord,
  input  logic signed [COORD_WIDTH-1:0] y_coord,
  input  logic signed [COORD_WIDTH-1:0] z_coord,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [COORD_WIDTH-1:0]        range_out,
  output logic [ANGLE_WIDTH-1:0]        bearing_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic                          cfg_data
);

  logic       compass_mode;
  logic       front_ready;
  logic       chain_valid [NUM_CELLS+1];
  logic       chain_ready [NUM_CELLS+1];
  cell_data_t chain_data  [NUM_CELLS+1];

  assign cfg_ready = 1'b1;
  assign in_stall  = !front_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      compass_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      compass_mode <= cfg_data;
    end
  end

  c2rb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .ready    (front_ready),
    .x_coord  (x_coord),
    .y_coord  (y_coord),
    .z_coord  (z_coord),
    .valid    (chain_valid[0]),
    .data     (chain_data[0]),
    .dn_ready (chain_ready[0])
  );

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    c2rb_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .idx      (CELL_IDX_W'(g)),
      .up_valid (chain_valid[g]),
      .ready    (chain_ready[g]),
      .up_data  (chain_data[g]),
      .valid    (chain_valid[g+1]),
      .data     (chain_data[g+1]),
      .dn_ready (chain_ready[g+1])
    );
  end

  c2rb_unfold u_unfold (
    .clk          (clk),
    .rst          (rst),
    .compass_mode (compass_mode),
    .up_valid     (chain_valid[NUM_CELLS]),
    .ready        (chain_ready[NUM_CELLS]),
    .up_data      (chain_data[NUM_CELLS]),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .range_out    (range_out),
    .bearing_out  (bearing_out)
  );

  // A free output lets every stage move, so the input is never stalled then.
  a_free_out_no_stall: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while the output is free");

  // Stalling the input needs a word held at the output.
  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with an empty output register");

  a_reset_empties: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output word present right after reset");

  a_mode_holds: assert property (@(posedge clk) disable iff (rst)
    !cfg_valid |=> $stable(compass_mode))
    else $error("compass mode changed without a write");

endmodule

### test/polar_checker.sv
// Checker for the range and bearing converter: watches the input, output and mode channels.
// Predicts every output word from the accepted input word and compares it field by field.
// Depends on c2rb_pkg for the coordinate and angle widths.
module polar_checker import c2rb_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [COORD_WIDTH-1:0] x_coord,
  input  logic signed [COORD_WIDTH-1:0] y_coord,
  input  logic signed [COORD_WIDTH-1:0] z_coord,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [COORD_WIDTH-1:0]        range_out,
  input  logic [ANGLE_WIDTH-1:0]        bearing_out,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic                          cfg_data,
  output int                            outstanding,
  output int                            mismatches
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [COORD_WIDTH-1:0] metres;
    logic [ANGLE_WIDTH-1:0] turn;
  } polar_t;

  localparam int ROTATIONS = 28;
  localparam logic [31:0] QUARTER = 32'h4000_0000;
  localparam logic [31:0] HALF = 32'h8000_0000;
  localparam longint OCTANT_LIMIT = 64'h2000_0000;
  localparam logic [31:0] ROTATION_TURNS [ROTATIONS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
    32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
    32'h00000014, 32'h0000000A, 32'h00000005
  };

  logic   compass;
  polar_t expected_polar [$];
  int     errors = 0;

  function automatic longint int_sqrt(input longint v);
    longint r;
    longint trial;
    r = 0;
    for (int k = COORD_WIDTH; k >= 0; k--) begin
      trial = r | (64'sd1 <<< k);
      if (trial * trial <= v) r = trial;
    end
    return r;
  endfunction

  function automatic logic [31:0] octant_turn(input longint big, input longint minor);
    longint cx;
    longint cy;
    longint acc;
    longint dx;
    longint dy;
    cx = big <<< 30;
    cy = minor <<< 30;
    acc = 0;
    for (int i = 0; i < ROTATIONS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cy >= 0) begin
        cx = cx + dx;
        cy = cy - dy;
        acc = acc + longint'(ROTATION_TURNS[i]);
      end else begin
        cx = cx - dx;
        cy = cy + dy;
        acc = acc - longint'(ROTATION_TURNS[i]);
      end
    end
    if (acc < 0) acc = 0;
    if (acc > OCTANT_LIMIT) acc = OCTANT_LIMIT;
    return acc[31:0];
  endfunction

  function automatic polar_t to_polar(input logic signed [COORD_WIDTH-1:0] x,
                                      input logic signed [COORD_WIDTH-1:0] y,
                                      input logic signed [COORD_WIDTH-1:0] z,
                                      input logic azimuth);
    longint sx;
    longint sy;
    longint sz;
    longint ax;
    longint ay;
    longint az;
    longint sum;
    longint root;
    logic [31:0] turn;
    logic [ANGLE_WIDTH-1:0] step;
    polar_t res;
    sx = x;
    sy = y;
    sz = z;
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    az = (sz < 0) ? -sz : sz;
    sum = ax * ax + ay * ay + az * az;
    root = int_sqrt(sum);
    if (sum - root * root > root) root = root + 1;
    if (ax == 0 && ay == 0) begin
      turn = '0;
    end else begin
      if (ay > ax) turn = QUARTER - octant_turn(ay, ax);
      else turn = octant_turn(ax, ay);
      if (sx < 0 && sy >= 0) turn = HALF - turn;
      else if (sx < 0 && sy < 0) turn = HALF + turn;
      else if (sx >= 0 && sy < 0) turn = 32'd0 - turn;
    end
    step = ANGLE_WIDTH'(({32'd0, turn} + (64'd1 << (31 - ANGLE_WIDTH))) >> (32 - ANGLE_WIDTH));
    if (azimuth) step = ANGLE_WIDTH'(1 << (ANGLE_WIDTH - 2)) - step;
    res.metres = COORD_WIDTH'(root);
    res.turn = step;
    return res;
  endfunction

  task automatic report(input string field, input longint want, input longint got);
    errors++;
    $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  always @(posedge clk) begin
    polar_t want;
    if (rst) begin
      compass <= 1'b0;
      expected_polar.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_polar.size() == 0) begin
          errors++;
          $display("%0t: unexpected word, expected none, actual range %0d bearing %0d",
                   $time, range_out, bearing_out);
        end else begin
          want = expected_polar.pop_front();
          if (range_out !== want.metres) report("range", want.metres, range_out);
          if (bearing_out !== want.turn) report("bearing", want.turn, bearing_out);
        end
      end
      if (in_valid && !in_stall)
        expected_polar.push_back(to_polar(x_coord, y_coord, z_coord, compass));
      if (cfg_valid && cfg_ready) compass <= cfg_data;
    end
    outstanding <= expected_polar.size();
    mismatches <= errors;
  end

endmodule

### test/tb_cartesian_to_range_bearing.sv
// Top of the range and bearing converter testbench: clock, reset, stimulus and verdict.
// Depends on c2rb_pkg, the converter RTL and the polar_checker module.
module tb_cartesian_to_range_bearing import c2rb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PERIOD = 10;
  localparam int CYCLE_LIMIT = 100000;
  localparam int DRAIN_CYCLES = 40;
  localparam logic MODE_MATH = 1'b0;
  localparam logic MODE_COMPASS = 1'b1;
  localparam logic signed [COORD_WIDTH-1:0] C_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
  localparam logic signed [COORD_WIDTH-1:0] C_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [COORD_WIDTH-1:0] x_coord = '0;
  logic signed [COORD_WIDTH-1:0] y_coord = '0;
  logic signed [COORD_WIDTH-1:0] z_coord = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [COORD_WIDTH-1:0]        range_out;
  logic [ANGLE_WIDTH-1:0]        bearing_out;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic                          cfg_data = 1'b0;
  int                            stall_pct = 61;
  int                            send_gap_pct = 27;
  int                            cycles = 0;
  int                            outstanding;
  int                            mismatches;

  always #(PERIOD / 2) clk = ~clk;

  cartesian_to_range_bearing u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .z_coord     (z_coord),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .range_out   (range_out),
    .bearing_out (bearing_out),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  polar_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .x_coord     (x_coord),
    .y_coord     (y_coord),
    .z_coord     (z_coord),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .range_out   (range_out),
    .bearing_out (bearing_out),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic signed [COORD_WIDTH-1:0] pick_coord();
    logic signed [COORD_WIDTH-1:0] v;
    v = COORD_WIDTH'($urandom);
    case ($urandom_range(5))
      0: v = COORD_WIDTH'(int'($urandom_range(16)) - 8);
      1: v = '0;
      2: begin
        case ($urandom_range(3))
          0: v = C_MAX;
          1: v = C_MIN;
          2: v = 1;
          default: v = -1;
        endcase
      end
      3, 4: v = v >>> $urandom_range(22);
      default: ;
    endcase
    return v;
  endfunction

  task automatic send_point(input logic signed [COORD_WIDTH-1:0] x,
                            input logic signed [COORD_WIDTH-1:0] y,
                            input logic signed [COORD_WIDTH-1:0] z);
    int gap;
    gap = 0;
    while (gap < 8 && $urandom_range(99) < send_gap_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    x_coord <= x;
    y_coord <= y;
    z_coord <= z;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_random();
    logic signed [COORD_WIDTH-1:0] z;
    z = $urandom_range(1) ? '0 : pick_coord();
    send_point(pick_coord(), pick_coord(), z);
  endtask

  // The sender holds off until the checker has seen every predicted word.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic write_mode(input logic mode);
    cfg_valid <= 1'b1;
    cfg_data <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_directed();
    send_point('0, '0, '0);
    send_point('0, '0, C_MAX);
    send_point('0, '0, C_MIN);
    send_point(5, '0, '0);
    send_point('0, 7, '0);
    send_point(-3, '0, '0);
    send_point('0, -9, '0);
    send_point(C_MAX, C_MAX, C_MAX);
    send_point(C_MIN, C_MIN, C_MIN);
    send_point(1, 1, '0);
    send_point(C_MAX, -1, '0);
    send_point(1, C_MIN, '0);
    send_point(C_MIN, C_MAX, -1);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_mode(MODE_MATH);
    run_directed();
    drain();
    write_mode(MODE_COMPASS);
    run_directed();
    drain();
    for (int n = 0; n < 130; n++) begin
      if (n == 60) drain();
      send_random();
    end
    drain();

    send_gap_pct = 61;
    stall_pct <= 27;
    write_mode(MODE_MATH);
    for (int n = 0; n < 135; n++) send_random();
    drain();

    send_gap_pct = 0;
    stall_pct <= 0;
    write_mode(MODE_COMPASS);
    for (int n = 0; n < 135; n++) send_random();
    drain();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
